// ===== design/hysteresis_pump_control_with_duty_core_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef HYSTERESIS_PUMP_CONTROL_WITH_DUTY_CORE_MACROS_SVH
`define HYSTERESIS_PUMP_CONTROL_WITH_DUTY_CORE_MACROS_SVH

// same-cycle implication
`define HPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpc assertion failed");

// next-cycle implication
`define HPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpc assertion failed");

`endif

// ===== design/hpc_pkg.sv =====
package hpc_pkg;

   localparam int TempWidth     = 12;
   localparam int HystWidth     = 9;
   localparam int TimeWidth     = 32;
   localparam int DutyWidth     = 7;
   localparam int CsrAddrWidth  = 2;
   localparam int CsrDataWidth  = 12;
   // temperatures compared at this width so start - hysteresis cannot overflow
   localparam int CmpWidth      = 14;
   localparam int DividendWidth = 40;
   localparam int DivSteps      = DividendWidth;
   localparam int DivCntWidth   = $clog2(DivSteps);

   localparam logic [CsrAddrWidth-1:0] CsrStartThreshold = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CsrHysteresis     = 2'd1;

   localparam logic signed [TempWidth-1:0] StartThresholdReset = 12'sd500;
   localparam logic [HystWidth-1:0]        HysteresisReset     = 9'd50;
   localparam logic [DutyWidth-1:0]        PercentFull         = 7'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic mul;
      logic div_step;
      logic out_load;
   } cmd_type;

endpackage

// ===== design/hpc_req_if.sv =====
interface hpc_req_if
   import hpc_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic signed [TempWidth-1:0] temperature;
   logic [TimeWidth-1:0]        now_ms;

   modport source (output valid, temperature, now_ms, input ready);
   modport sink   (input valid, temperature, now_ms, output ready);
endinterface

// ===== design/hpc_rsp_if.sv =====
interface hpc_rsp_if
   import hpc_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 pump_on;
   logic [TimeWidth-1:0] session_ms;
   logic [TimeWidth-1:0] total_on_ms;
   logic [DutyWidth-1:0] duty_percent;

   modport source (output valid, pump_on, session_ms, total_on_ms, duty_percent,
                   input ready);
   modport sink   (input valid, pump_on, session_ms, total_on_ms, duty_percent,
                   output ready);
endinterface

// ===== design/hpc_ctrl.sv =====
module hpc_ctrl
   import hpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type              state_ff, state_in;
   logic [DivCntWidth-1:0] cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = DivCntWidth'(DivSteps - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait until the output register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== design/hpc_datapath.sv =====
module hpc_datapath
   import hpc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   input  logic                        csr_we,
   input  logic [CsrAddrWidth-1:0]     csr_addr,
   input  logic [CsrDataWidth-1:0]     csr_wdata,
   input  logic signed [TempWidth-1:0] req_temperature,
   input  logic [TimeWidth-1:0]        req_now_ms,
   output logic                        rsp_pump_on,
   output logic [TimeWidth-1:0]        rsp_session_ms,
   output logic [TimeWidth-1:0]        rsp_total_on_ms,
   output logic [DutyWidth-1:0]        rsp_duty_percent
);

   logic signed [TempWidth-1:0] start_ff, start_in;
   logic [HystWidth-1:0]        hyst_ff, hyst_in;
   logic                        pump_ff, pump_in;
   logic [TimeWidth-1:0]        start_ms_ff, start_ms_in;
   logic [TimeWidth-1:0]        closed_ff, closed_in;

   logic signed [TempWidth-1:0] temp_ff;
   logic [TimeWidth-1:0]        now_ff;
   logic [TimeWidth-1:0]        session_ff, session_in;
   logic [TimeWidth-1:0]        total_ff, total_in;
   logic [DividendWidth-1:0]    dvd_ff, dvd_in;
   logic [TimeWidth-1:0]        rem_ff, rem_in;

   logic                        out_pump_ff;
   logic [TimeWidth-1:0]        out_session_ff, out_total_ff;
   logic [DutyWidth-1:0]        out_duty_ff, duty_in;

   logic signed [CmpWidth-1:0]  temp_x, start_x, stop_x;
   logic                        on_next;
   logic [TimeWidth:0]          rem_shift, rem_diff;

   // configuration registers
   always_comb begin
      start_in = start_ff;
      hyst_in  = hyst_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CsrStartThreshold: start_in = csr_wdata[TempWidth-1:0];
            CsrHysteresis:     hyst_in  = csr_wdata[HystWidth-1:0];
            default: ;
         endcase
      end
   end

   // hysteresis decision and time accounting
   always_comb begin
      temp_x  = CmpWidth'(temp_ff);
      start_x = CmpWidth'(start_ff);
      stop_x  = start_x - $signed({{(CmpWidth-HystWidth){1'b0}}, hyst_ff});
      if (pump_ff) begin
         on_next = !(temp_x <= stop_x);
      end else begin
         on_next = (temp_x >= start_x);
      end

      pump_in     = pump_ff;
      start_ms_in = start_ms_ff;
      closed_in   = closed_ff;
      if (cmd.eval) begin
         pump_in = on_next;
         if (on_next && !pump_ff) begin
            start_ms_in = now_ff;
         end
         if (!on_next && pump_ff) begin
            closed_in = closed_ff + (now_ff - start_ms_ff);
         end
      end
      session_in = on_next ? (now_ff - start_ms_in) : '0;
      total_in   = closed_in + session_in;
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DividendWidth-1]};
      rem_diff  = rem_shift - {1'b0, now_ff};
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      if (cmd.mul) begin
         dvd_in = ({{(DividendWidth-TimeWidth){1'b0}}, total_ff}
                   * DividendWidth'(PercentFull))
                  + DividendWidth'(now_ff >> 1);
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (!rem_diff[TimeWidth]) begin
            rem_in = rem_diff[TimeWidth-1:0];
            dvd_in = {dvd_ff[DividendWidth-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[TimeWidth-1:0];
            dvd_in = {dvd_ff[DividendWidth-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (now_ff == '0) begin
         duty_in = '0;
      end else if (dvd_ff > DividendWidth'(PercentFull)) begin
         duty_in = PercentFull;
      end else begin
         duty_in = dvd_ff[DutyWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= StartThresholdReset;
         hyst_ff     <= HysteresisReset;
         pump_ff     <= 1'b0;
         start_ms_ff <= '0;
         closed_ff   <= '0;
      end else begin
         start_ff    <= start_in;
         hyst_ff     <= hyst_in;
         pump_ff     <= pump_in;
         start_ms_ff <= start_ms_in;
         closed_ff   <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         temp_ff <= req_temperature;
         now_ff  <= req_now_ms;
      end
      if (cmd.eval) begin
         session_ff <= session_in;
         total_ff   <= total_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (cmd.out_load) begin
         out_pump_ff    <= pump_ff;
         out_session_ff <= session_ff;
         out_total_ff   <= total_ff;
         out_duty_ff    <= duty_in;
      end
   end

   assign rsp_pump_on      = out_pump_ff;
   assign rsp_session_ms   = out_session_ff;
   assign rsp_total_on_ms  = out_total_ff;
   assign rsp_duty_percent = out_duty_ff;

endmodule

// ===== design/hysteresis_pump_control_with_duty_core.sv =====
// Hysteresis pump controller with on-time accounting. Each request carries a
// temperature in tenths of a degree and a millisecond timestamp; the block
// switches the pump on at start_threshold and off at or below
// start_threshold - hysteresis, tracks session and total on time, and returns
// one response per request with the rounded duty percentage (0 at time 0,
// capped at 100). A request passes through these steps in order: capture,
// decide and update the on-time counters, form the 40-bit dividend, run the
// bit-serial divider that produces the percentage, and move the result into
// the output register once it is free or being drained. Only one request is
// in flight; the next is taken while the previous response still waits in
// the output register. Configuration writes through csr_* take effect at the
// next clock edge and must be made while the block is idle; indices other
// than 0 (start_threshold) and 1 (hysteresis) are ignored.
module hysteresis_pump_control_with_duty_core
   import hpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   hpc_req_if.sink                 req,
   hpc_rsp_if.source               rsp
);

   cmd_type cmd;

   hpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   hpc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_temperature  (req.temperature),
      .req_now_ms       (req.now_ms),
      .rsp_pump_on      (rsp.pump_on),
      .rsp_session_ms   (rsp.session_ms),
      .rsp_total_on_ms  (rsp.total_on_ms),
      .rsp_duty_percent (rsp.duty_percent)
   );

endmodule

// ===== design/hpc_checker.sv =====
`include "hysteresis_pump_control_with_duty_core_macros.svh"

module hpc_checker
   import hpc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_pump_on,
   input logic [TimeWidth-1:0] rsp_session_ms,
   input logic [DutyWidth-1:0] rsp_duty_percent
);

   // a held response keeps its payload
   `HPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_session_ms) && $stable(rsp_duty_percent))
   // duty is capped at 100
   `HPC_ASSERT_NOW(a_duty_cap, clock, reset, rsp_valid, rsp_duty_percent <= PercentFull)
   // no session time while the pump is off
   `HPC_ASSERT_NOW(a_off_session, clock, reset, rsp_valid && !rsp_pump_on, rsp_session_ms == '0)
   // one request in flight at a time
   `HPC_ASSERT_NEXT(a_one_request, clock, reset, req_valid && req_ready, !req_ready)
   // reset empties the output register
   `HPC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind hysteresis_pump_control_with_duty_core hpc_checker u_hpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_pump_on      (rsp.pump_on),
   .rsp_session_ms   (rsp.session_ms),
   .rsp_duty_percent (rsp.duty_percent)
);

// ===== sim/tb_top.sv =====
module tb_top;
   import hpc_pkg::*;

   typedef struct packed {
      logic                 pump_on;
      logic [TimeWidth-1:0] session_ms;
      logic [TimeWidth-1:0] total_on_ms;
      logic [DutyWidth-1:0] duty_percent;
   } pump_report_type;

   // indexes past the last register; writes there must be dropped
   localparam logic [CsrAddrWidth-1:0] CsrSpareA = 2'd2;
   localparam logic [CsrAddrWidth-1:0] CsrSpareB = 2'd3;
   localparam int SettleCycles = 60;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CsrAddrWidth-1:0] csr_addr;
   logic [CsrDataWidth-1:0] csr_wdata;

   hpc_req_if req ();
   hpc_rsp_if rsp ();

   hysteresis_pump_control_with_duty_core u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req       (req),
      .rsp       (rsp)
   );

   // pump controller state as the block should hold it
   logic signed [TempWidth-1:0] model_threshold     = StartThresholdReset;
   logic [HystWidth-1:0]        model_hysteresis    = HysteresisReset;
   logic                        model_pump_on       = 1'b0;
   logic [TimeWidth-1:0]        model_session_start = '0;
   logic [TimeWidth-1:0]        model_closed_total  = '0;

   pump_report_type      pending_reports[$];
   int                   error_count     = 0;
   logic                 sender_idles    = 1'b1;
   logic                 receiver_stalls = 1'b1;
   logic [TimeWidth-1:0] clock_ms        = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic pump_report_type advance_pump(input logic signed [TempWidth-1:0] temp,
                                                    input logic [TimeWidth-1:0] now);
      pump_report_type rpt;
      logic            was_on;
      logic [63:0]     quot;
      was_on = model_pump_on;
      if (!was_on && int'(temp) >= int'(model_threshold)) begin
         model_pump_on = 1'b1;
      end else if (was_on &&
                   int'(temp) <= int'(model_threshold) - int'(model_hysteresis)) begin
         model_pump_on = 1'b0;
      end
      if (model_pump_on && !was_on) begin
         model_session_start = now;
      end
      if (!model_pump_on && was_on) begin
         model_closed_total = model_closed_total + (now - model_session_start);
      end
      rpt.pump_on      = model_pump_on;
      rpt.session_ms   = model_pump_on ? now - model_session_start : '0;
      rpt.total_on_ms  = model_closed_total + rpt.session_ms;
      rpt.duty_percent = '0;
      if (now != '0) begin
         // rounded share, done at 64 bits so total * 100 cannot overflow
         quot = (64'(rpt.total_on_ms) * 64'd100 + 64'(now >> 1)) / 64'(now);
         rpt.duty_percent = (quot > 64'd100) ? PercentFull : quot[DutyWidth-1:0];
      end
      return rpt;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : track_pump
      pump_report_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_addr)
               CsrStartThreshold: model_threshold  = csr_wdata;
               CsrHysteresis:     model_hysteresis = csr_wdata[HystWidth-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: unexpected result: expected none, got pump_on=%0b %s%0d %s%0d %s%0d",
                        $time, rsp.pump_on, "session_ms=", rsp.session_ms,
                        "total_on_ms=", rsp.total_on_ms, "duty_percent=", rsp.duty_percent);
               error_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("pump_on", 32'(want.pump_on), 32'(rsp.pump_on));
               check_field("session_ms", want.session_ms, rsp.session_ms);
               check_field("total_on_ms", want.total_on_ms, rsp.total_on_ms);
               check_field("duty_percent", 32'(want.duty_percent), 32'(rsp.duty_percent));
            end
         end
         if (req.valid && req.ready) begin
            pending_reports.push_back(advance_pump(req.temperature, req.now_ms));
         end
      end
   end

   initial begin
      rsp.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic send_reading(input int temp, input logic [TimeWidth-1:0] now);
      req.valid       <= 1'b1;
      req.temperature <= TempWidth'(temp);
      req.now_ms      <= now;
      do @(posedge clock); while (!req.ready);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every response is back
   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrAddrWidth-1:0] idx,
                                 input logic [CsrDataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // reset values: 500 start, 450 stop; zero time gives zero duty
   task automatic test_turn_on_off();
      send_reading(499, 0);
      send_reading(500, 0);
      send_reading(451, 1000);
      send_reading(450, 4000);
      send_reading(2047, 8000);
      send_reading(-2048, 10000);
   endtask

   task automatic test_register_extremes();
      drain_results();
      write_register(CsrStartThreshold, 12'd1500);
      write_register(CsrHysteresis, 12'd500);
      send_reading(1499, 12000);
      send_reading(1500, 13000);
      send_reading(1001, 14000);
      send_reading(1000, 15000);
      // zero hysteresis: on and off at the same level, so a reading there toggles the pump
      drain_results();
      write_register(CsrStartThreshold, 12'(-400));
      write_register(CsrHysteresis, 12'd0);
      send_reading(-401, 16000);
      send_reading(-400, 17000);
      send_reading(-399, 18000);
      send_reading(-400, 19000);
      send_reading(-400, 20000);
   endtask

   // stop level -2048 - 511 is below any 12-bit temperature
   task automatic test_deep_stop_level();
      drain_results();
      write_register(CsrStartThreshold, 12'h800);
      write_register(CsrHysteresis, 12'hFFF);
      send_reading(-2048, 21000);
      send_reading(-2048, 22000);
   endtask

   // time going backwards wraps the differences; duty saturates
   task automatic test_time_wrap();
      send_reading(-2048, 500);
      send_reading(-2048, 32'hFFFF_FFFF);
      drain_results();
      write_register(CsrHysteresis, 12'd0);
      send_reading(-2048, 300);
      send_reading(0, 0);
   endtask

   task automatic test_spare_registers();
      drain_results();
      write_register(CsrSpareA, 12'hFFF);
      write_register(CsrSpareB, 12'h000);
      send_reading(-2048, 5000);
      send_reading(-2048, 6000);
   endtask

   task automatic run_random_phase(input logic [CsrDataWidth-1:0] threshold,
                                   input logic [CsrDataWidth-1:0] hyst, input int count);
      int                   stop_level;
      int                   temp;
      logic [TimeWidth-1:0] now;
      drain_results();
      write_register(CsrStartThreshold, threshold);
      write_register(CsrHysteresis, hyst);
      stop_level = int'($signed(threshold)) - int'(hyst[HystWidth-1:0]);
      repeat (count) begin
         // mostly hover around the switching levels so the pump keeps cycling
         case ($urandom_range(0, 9))
            0:          temp = int'($urandom_range(0, 4095));
            1, 2, 3, 4: temp = int'($signed(threshold)) + int'($urandom_range(0, 20)) - 10;
            5, 6, 7, 8: temp = stop_level + int'($urandom_range(0, 20)) - 10;
            default:    temp = int'($urandom_range(0, 1900)) - 400;
         endcase
         clock_ms = clock_ms + $urandom_range(0, 3000);
         now = clock_ms;
         case ($urandom_range(0, 19))
            0:       now = $urandom();
            1:       now = clock_ms - $urandom_range(1, 5000);
            2:       now = '0;
            default: ;
         endcase
         send_reading(temp, now);
         if (sender_idles && $urandom_range(0, 49) == 0) begin
            drain_results();
         end
      end
   endtask

   task automatic test_random_phases();
      run_random_phase(12'd500, 12'd50, 80);
      run_random_phase(12'd1500, 12'd500, 80);
      run_random_phase(12'(-400), 12'd0, 80);
      run_random_phase(12'h7FF, 12'h1FF, 80);
      run_random_phase(12'h800, 12'h1FF, 80);
      run_random_phase(12'(int'($urandom_range(0, 1900)) - 400), 12'($urandom_range(0, 500)),
                       80);
      run_random_phase(12'd100, 12'd5, 80);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      run_random_phase(12'($urandom()), 12'($urandom()), 80);
   endtask

   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_addr        <= CsrStartThreshold;
      csr_wdata       <= '0;
      req.valid       <= 1'b0;
      req.temperature <= '0;
      req.now_ms      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_turn_on_off();
      test_register_extremes();
      test_deep_stop_level();
      test_time_wrap();
      test_spare_registers();
      test_random_phases();
      drain_results();
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
